// ===== hdl/edf_dynamic_sporadic_server_unit_defines.svh =====
// assertion macros shared by the edf sporadic server rtl
// depends on nothing; included by files that carry assertions
`ifndef EDF_DYNAMIC_SPORADIC_SERVER_UNIT_DEFINES_SVH
`define EDF_DYNAMIC_SPORADIC_SERVER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define EDFSS_ASSERT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("edfss assertion failed");
// next-cycle implication
`define EDFSS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("edfss assertion failed");
`else
`define EDFSS_ASSERT(lbl, clk, rst, ante, cons)
`define EDFSS_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/edfss_pkg.sv =====
// types and constants of the edf sporadic server
// depends on nothing
package edfss_pkg;

   localparam int TIME_W = 24;
   localparam int WORK_W = 16;
   localparam int SLOT_W = 4;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [TIME_W-1:0] MAX_TIME = 24'hFFFFFF;
   localparam logic [WORK_W-1:0] MAX_WORK = 16'hFFFF;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SERVER_PERIOD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INITIAL_BUDGET = 1'd1;

   localparam logic [WORK_W-1:0] RST_SERVER_PERIOD = 16'd8;
   localparam logic [WORK_W-1:0] RST_INITIAL_BUDGET = 16'd2;

   // item kinds
   localparam logic KIND_RELEASE = 1'b0;
   localparam logic KIND_STEP = 1'b1;

   // result status codes
   localparam logic [1:0] ST_REL_OK = 2'd0;
   localparam logic [1:0] ST_REL_BUSY = 2'd1;
   localparam logic [1:0] ST_STEP = 2'd2;
   localparam logic [1:0] ST_STEP_OVF = 2'd3;

   // controller to datapath commands
   typedef struct packed {
      logic req_load;
      logic rel_exec;
      logic repl_chk;
      logic chg_exec;
      logic scan_issue;
      logic decide;
      logic rsp_load;
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic repl_due;
   } dp_stat_type;

endpackage

// ===== hdl/edfss_ctrl.sv =====
// controller state machine of the edf sporadic server
// depends on edfss_pkg and the assertion macro header
`include "edf_dynamic_sporadic_server_unit_defines.svh"
module edfss_ctrl #(
   parameter int NUM_SLOTS = 16,
   parameter int SW = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_kind,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output edfss_pkg::dp_cmd_type      cmd,
   input  edfss_pkg::dp_stat_type     stat,
   output logic [SW-1:0]              scan_addr
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_REL = 4'd1;
   localparam logic [3:0] S_RP_RD = 4'd2;
   localparam logic [3:0] S_RP_CHK = 4'd3;
   localparam logic [3:0] S_CH_RD = 4'd4;
   localparam logic [3:0] S_CH_EX = 4'd5;
   localparam logic [3:0] S_SCAN = 4'd6;
   localparam logic [3:0] S_SCAN_LAST = 4'd7;
   localparam logic [3:0] S_DEC = 4'd8;
   localparam logic [3:0] S_FIN = 4'd9;

   logic [3:0]    state_ff, state_in;
   logic [SW-1:0] scan_cnt_ff, scan_cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept, out_free, scan_last;

   assign accept = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign scan_last = scan_cnt_ff == SW'(NUM_SLOTS - 1);
   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign scan_addr = scan_cnt_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      scan_cnt_in = scan_cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.req_load = 1'b1;
               state_in = (req_kind == edfss_pkg::KIND_STEP) ? S_RP_RD : S_REL;
            end
         end
         S_REL: begin
            cmd.rel_exec = 1'b1;
            state_in = S_FIN;
         end
         S_RP_RD: state_in = S_RP_CHK;
         S_RP_CHK: begin
            cmd.repl_chk = 1'b1;
            state_in = stat.repl_due ? S_RP_RD : S_CH_RD;
         end
         S_CH_RD: state_in = S_CH_EX;
         S_CH_EX: begin
            cmd.chg_exec = 1'b1;
            scan_cnt_in = '0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (scan_last) begin
               state_in = S_SCAN_LAST;
            end else begin
               scan_cnt_in = scan_cnt_ff + 1'b1;
            end
         end
         S_SCAN_LAST: state_in = S_DEC;
         S_DEC: begin
            cmd.decide = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         scan_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         scan_cnt_ff <= scan_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `EDFSS_ASSERT_NXT(a_rel_to_fin, clock, reset, state_ff == S_REL, state_ff == S_FIN)
   `EDFSS_ASSERT_NXT(a_scan_ends, clock, reset, state_ff == S_SCAN && scan_last,
      state_ff == S_SCAN_LAST)
   `EDFSS_ASSERT_NXT(a_accept_route, clock, reset, accept,
      state_ff == S_REL || state_ff == S_RP_RD)
   `EDFSS_ASSERT(a_word_from_fin, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff) == S_FIN)

endmodule

// ===== hdl/edfss_dp.sv =====
// datapath of the edf sporadic server: slot memories, replenishment queue,
// budget, time and the deadline scan; depends on edfss_pkg
module edfss_dp #(
   parameter int NUM_SLOTS = 16,
   parameter int REPL_DEPTH = 8,
   parameter int SW = 4
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  edfss_pkg::dp_cmd_type                   cmd,
   output edfss_pkg::dp_stat_type                  stat,
   input  logic [SW-1:0]                           scan_addr,
   input  logic [edfss_pkg::SLOT_W-1:0]            req_job_slot,
   input  logic                                    req_is_periodic,
   input  logic [edfss_pkg::WORK_W-1:0]            req_work_ticks,
   input  logic [edfss_pkg::TIME_W-1:0]            req_abs_deadline,
   input  logic                                    csr_wr_en,
   input  logic [edfss_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [edfss_pkg::CSR_DATA_W-1:0]        csr_wdata,
   output logic [1:0]                              rsp_status,
   output logic [edfss_pkg::SLOT_W-1:0]            rsp_running_slot,
   output logic                                    rsp_idle,
   output logic [edfss_pkg::WORK_W-1:0]            rsp_budget_left,
   output logic [edfss_pkg::TIME_W-1:0]            rsp_time_now
);

   localparam int PW = (REPL_DEPTH > 1) ? $clog2(REPL_DEPTH) : 1;
   localparam int CW = $clog2(REPL_DEPTH + 1);
   localparam int AW = $clog2(NUM_SLOTS + 1);
   localparam int TW = edfss_pkg::TIME_W;
   localparam int WW = edfss_pkg::WORK_W;

   // latched request word
   logic [edfss_pkg::SLOT_W-1:0] q_slot_ff;
   logic          q_per_ff;
   logic [WW-1:0] q_work_ff;
   logic [TW-1:0] q_dl_ff;

   // slot memories and read port
   logic [NUM_SLOTS-1:0] slot_valid_ff;
   logic          mem_per [NUM_SLOTS];
   logic [WW-1:0] mem_rem [NUM_SLOTS];
   logic [TW-1:0] mem_dl [NUM_SLOTS];
   logic          rd_per_ff;
   logic [WW-1:0] rd_rem_ff;
   logic [TW-1:0] rd_dl_ff;
   logic [SW-1:0] rd_addr;

   // replenishment queue
   logic [TW-1:0] fifo_t [REPL_DEPTH];
   logic [WW-1:0] fifo_a [REPL_DEPTH];
   logic [TW-1:0] fifo_rd_t_ff;
   logic [WW-1:0] fifo_rd_a_ff;
   logic [PW-1:0] head_ff, tail_ff, last_ff;
   logic [CW-1:0] count_ff;
   logic [TW-1:0] last_time_ff;
   logic [WW-1:0] last_amt_ff;

   // scheduler state
   logic [WW-1:0] period_ff, budget_ff, consumed_ff;
   logic [TW-1:0] time_ff, pred_time_ff, server_dl_ff;
   logic [AW-1:0] acnt_ff;
   logic [SW-1:0] running_job_ff;
   logic          running_valid_ff, predicting_ff;
   logic          prev_run_ff, prev_per_ff;

   // scan pipeline and best candidate
   logic          scan_pv_ff;
   logic [SW-1:0] scan_idx_ff;
   logic          found_ff, best_per_ff;
   logic [SW-1:0] best_idx_ff;
   logic [TW-1:0] best_dl_ff;
   logic [WW-1:0] best_rem_ff;

   // held result fields
   logic [1:0]    res_status_ff;
   logic [TW-1:0] res_time_ff;

   logic [SW-1:0] rel_idx;
   logic          rel_ok;
   logic [WW:0]   repl_sum;
   logic          prun;
   logic [TW:0]   dl_sum;
   logic          sc_valid, sc_retire, sc_elig, sc_take;
   logic [TW-1:0] sc_dl;
   logic          d_start, d_pred, d_post, d_merge, d_push, d_ovf, d_nz, d_full;
   logic [TW-1:0] d_ptime;
   logic [WW-1:0] d_pamt;
   logic [WW:0]   merge_sum;
   logic [WW-1:0] merge_amt;

   // release check
   assign rel_idx = SW'(q_slot_ff);
   assign rel_ok = (32'(q_slot_ff) < NUM_SLOTS) && !slot_valid_ff[rel_idx];

   // head of queue due
   assign stat.repl_due = (count_ff != '0) && (fifo_rd_t_ff <= time_ff);
   assign repl_sum = {1'b0, budget_ff} + {1'b0, fifo_rd_a_ff};

   // charge of last tick's job
   assign prun = running_valid_ff && slot_valid_ff[running_job_ff];
   assign dl_sum = {1'b0, time_ff} + {{(TW - WW + 1){1'b0}}, period_ff};
   assign rd_addr = cmd.scan_issue ? scan_addr : running_job_ff;

   // scan compare
   always_comb begin
      sc_valid = scan_pv_ff && slot_valid_ff[scan_idx_ff];
      sc_retire = sc_valid && (rd_rem_ff == '0);
      sc_elig = sc_valid && !sc_retire && (rd_per_ff || (budget_ff != '0));
      sc_dl = rd_per_ff ? rd_dl_ff : server_dl_ff;
      if (!found_ff) begin
         sc_take = 1'b1;
      end else if (sc_dl != best_dl_ff) begin
         sc_take = sc_dl < best_dl_ff;
      end else if (rd_per_ff != best_per_ff) begin
         sc_take = !rd_per_ff;
      end else begin
         sc_take = rd_rem_ff < best_rem_ff;
      end
   end

   // prediction start and replenishment posting
   always_comb begin
      d_start = found_ff && !best_per_ff && (!prev_run_ff || prev_per_ff) && !predicting_ff;
      d_pred = predicting_ff || d_start;
      d_ptime = d_start ? server_dl_ff : pred_time_ff;
      d_pamt = d_start ? '0 : consumed_ff;
      d_post = d_pred && ((budget_ff == '0) || (acnt_ff == '0));
      d_nz = d_post && (d_pamt != '0);
      d_full = count_ff == CW'(REPL_DEPTH);
      d_merge = d_nz && (count_ff != '0) && (last_time_ff == d_ptime);
      d_push = d_nz && !d_merge && !d_full;
      d_ovf = d_nz && !d_merge && d_full;
      merge_sum = {1'b0, last_amt_ff} + {1'b0, d_pamt};
      merge_amt = merge_sum[WW] ? edfss_pkg::MAX_WORK : merge_sum[WW-1:0];
   end

   // memories, read data and request latch
   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         q_slot_ff <= req_job_slot;
         q_per_ff <= req_is_periodic;
         q_work_ff <= req_work_ticks;
         q_dl_ff <= req_abs_deadline;
      end
      if (cmd.rel_exec && rel_ok) begin
         mem_per[rel_idx] <= q_per_ff;
         mem_rem[rel_idx] <= q_work_ff;
         mem_dl[rel_idx] <= q_dl_ff;
      end else if (cmd.chg_exec && prun && (rd_rem_ff != '0)) begin
         mem_rem[running_job_ff] <= rd_rem_ff - 1'b1;
      end
      rd_per_ff <= mem_per[rd_addr];
      rd_rem_ff <= mem_rem[rd_addr];
      rd_dl_ff <= mem_dl[rd_addr];
      if (cmd.decide && d_merge) begin
         fifo_a[last_ff] <= merge_amt;
      end else if (cmd.decide && d_push) begin
         fifo_t[tail_ff] <= d_ptime;
         fifo_a[tail_ff] <= d_pamt;
      end
      fifo_rd_t_ff <= fifo_t[head_ff];
      fifo_rd_a_ff <= fifo_a[head_ff];
      scan_idx_ff <= scan_addr;
      if (cmd.chg_exec) begin
         server_dl_ff <= dl_sum[TW] ? edfss_pkg::MAX_TIME : dl_sum[TW-1:0];
      end
      if (scan_pv_ff && sc_elig && sc_take) begin
         best_per_ff <= rd_per_ff;
         best_idx_ff <= scan_idx_ff;
         best_dl_ff <= sc_dl;
         best_rem_ff <= rd_rem_ff;
      end
      if (cmd.rel_exec) begin
         res_status_ff <= rel_ok ? edfss_pkg::ST_REL_OK : edfss_pkg::ST_REL_BUSY;
         res_time_ff <= time_ff;
      end else if (cmd.decide) begin
         res_status_ff <= d_ovf ? edfss_pkg::ST_STEP_OVF : edfss_pkg::ST_STEP;
         res_time_ff <= time_ff;
      end
      if (cmd.rsp_load) begin
         rsp_status <= res_status_ff;
         rsp_running_slot <= edfss_pkg::SLOT_W'(running_job_ff);
         rsp_idle <= !running_valid_ff;
         rsp_budget_left <= budget_ff;
         rsp_time_now <= res_time_ff;
      end
   end

   // scheduler control state
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         head_ff <= '0;
         tail_ff <= '0;
         last_ff <= '0;
         count_ff <= '0;
         last_time_ff <= '0;
         last_amt_ff <= '0;
         period_ff <= edfss_pkg::RST_SERVER_PERIOD;
         budget_ff <= edfss_pkg::RST_INITIAL_BUDGET;
         consumed_ff <= '0;
         time_ff <= '0;
         pred_time_ff <= '0;
         acnt_ff <= '0;
         running_job_ff <= '0;
         running_valid_ff <= 1'b0;
         predicting_ff <= 1'b0;
         prev_run_ff <= 1'b0;
         prev_per_ff <= 1'b0;
         scan_pv_ff <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         scan_pv_ff <= cmd.scan_issue;
         // release
         if (cmd.rel_exec && rel_ok) begin
            slot_valid_ff[rel_idx] <= 1'b1;
            if (!q_per_ff) begin
               acnt_ff <= acnt_ff + 1'b1;
            end
         end
         // due replenishment
         if (cmd.repl_chk && stat.repl_due) begin
            budget_ff <= repl_sum[WW] ? edfss_pkg::MAX_WORK : repl_sum[WW-1:0];
            head_ff <= (head_ff == PW'(REPL_DEPTH - 1)) ? '0 : head_ff + 1'b1;
            count_ff <= count_ff - 1'b1;
         end
         // charge
         if (cmd.chg_exec) begin
            prev_run_ff <= prun;
            prev_per_ff <= rd_per_ff;
            found_ff <= 1'b0;
            if (prun && !rd_per_ff) begin
               if (budget_ff != '0) begin
                  budget_ff <= budget_ff - 1'b1;
               end
               if (predicting_ff && (consumed_ff != edfss_pkg::MAX_WORK)) begin
                  consumed_ff <= consumed_ff + 1'b1;
               end
            end
         end
         // retire and pick
         if (sc_retire) begin
            slot_valid_ff[scan_idx_ff] <= 1'b0;
            if (!rd_per_ff && (acnt_ff != '0)) begin
               acnt_ff <= acnt_ff - 1'b1;
            end
         end
         if (scan_pv_ff && sc_elig && sc_take) begin
            found_ff <= 1'b1;
         end
         // decision
         if (cmd.decide) begin
            predicting_ff <= d_post ? 1'b0 : d_pred;
            pred_time_ff <= d_ptime;
            consumed_ff <= d_pamt;
            if (d_merge) begin
               last_amt_ff <= merge_amt;
            end else if (d_push) begin
               last_ff <= tail_ff;
               tail_ff <= (tail_ff == PW'(REPL_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
               count_ff <= count_ff + 1'b1;
               last_time_ff <= d_ptime;
               last_amt_ff <= d_pamt;
            end
            running_valid_ff <= found_ff;
            running_job_ff <= found_ff ? best_idx_ff : '0;
            if (time_ff != edfss_pkg::MAX_TIME) begin
               time_ff <= time_ff + 1'b1;
            end
         end
         // register writes, a capacity write loads the live budget
         if (csr_wr_en) begin
            case (csr_index)
               edfss_pkg::REG_SERVER_PERIOD: period_ff <= csr_wdata;
               edfss_pkg::REG_INITIAL_BUDGET: budget_ff <= csr_wdata;
               default: period_ff <= period_ff;
            endcase
         end
      end
   end

endmodule

// ===== hdl/edf_dynamic_sporadic_server_unit.sv =====
// top level of the edf scheduler with dynamic sporadic server
// depends on edfss_pkg, edfss_ctrl and edfss_dp
//
//   channel  dir  handshake            word
//   req      in   req_valid/req_stall  kind, job_slot, is_periodic, work, deadline
//   rsp      out  rsp_valid/rsp_stall  status, running slot, idle, budget, time
//   csr      in   csr_wr_en            csr_index, csr_wdata
//
// a release goes from accept through the release and finish states to the result; a step
// goes through a read and check per replenishment due, the read and charge, then the deadline
// scan of one slot per cycle through the slot memory read port, the decision and the finish state
// reset is synchronous; the queue and slot memories need no clearing pass
// a stalled result waits in the output register; the next word is taken meanwhile
module edf_dynamic_sporadic_server_unit #(
   parameter int NUM_SLOTS = 16,
   parameter int REPL_DEPTH = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_kind,
   input  logic [edfss_pkg::SLOT_W-1:0]        req_job_slot,
   input  logic                                req_is_periodic,
   input  logic [edfss_pkg::WORK_W-1:0]        req_work_ticks,
   input  logic [edfss_pkg::TIME_W-1:0]        req_abs_deadline,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_status,
   output logic [edfss_pkg::SLOT_W-1:0]        rsp_running_slot,
   output logic                                rsp_idle,
   output logic [edfss_pkg::WORK_W-1:0]        rsp_budget_left,
   output logic [edfss_pkg::TIME_W-1:0]        rsp_time_now,
   input  logic                                csr_wr_en,
   input  logic [edfss_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [edfss_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int SW = $clog2(NUM_SLOTS);

   edfss_pkg::dp_cmd_type  cmd;
   edfss_pkg::dp_stat_type stat;
   logic [SW-1:0]          scan_addr;

   // sequencer
   edfss_ctrl #(
      .NUM_SLOTS(NUM_SLOTS),
      .SW(SW)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_kind(req_kind),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .cmd(cmd),
      .stat(stat),
      .scan_addr(scan_addr)
   );

   // storage and arithmetic
   edfss_dp #(
      .NUM_SLOTS(NUM_SLOTS),
      .REPL_DEPTH(REPL_DEPTH),
      .SW(SW)
   ) u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .stat(stat),
      .scan_addr(scan_addr),
      .req_job_slot(req_job_slot),
      .req_is_periodic(req_is_periodic),
      .req_work_ticks(req_work_ticks),
      .req_abs_deadline(req_abs_deadline),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .rsp_status(rsp_status),
      .rsp_running_slot(rsp_running_slot),
      .rsp_idle(rsp_idle),
      .rsp_budget_left(rsp_budget_left),
      .rsp_time_now(rsp_time_now)
   );

endmodule
